### rtl/core/life_like_automaton_stencil_defines.svh
// Assertion macros shared by the life-like automaton stencil RTL.
`ifndef LIFE_LIKE_AUTOMATON_STENCIL_DEFINES_SVH
`define LIFE_LIKE_AUTOMATON_STENCIL_DEFINES_SVH

// Same-cycle implication on clk, off while arst_n is low.
`define LLA_ASSERT_IMPLY(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication on clk, off while arst_n is low.
`define LLA_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

### rtl/core/lla_pkg.sv
// Shared constants and types for the life-like automaton stencil.
package lla_pkg;

	localparam int MAX_SIZE   = 1024;
	localparam int MIN_SIZE   = 3;
	localparam int ADDR_W     = $clog2(MAX_SIZE);
	localparam int ROW_W      = $clog2(MAX_SIZE + 2);
	localparam int CELL_W     = 10;
	localparam int GRID_W     = 11;
	localparam int RULE_W     = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = GRID_W;

	localparam logic [GRID_W-1:0] GRID_RESET         = GRID_W'(1000);
	localparam logic [RULE_W-1:0] SURVIVE_LOW_RESET  = RULE_W'(2);
	localparam logic [RULE_W-1:0] SURVIVE_HIGH_RESET = RULE_W'(3);
	localparam logic [RULE_W-1:0] BIRTH_LOW_RESET    = RULE_W'(3);
	localparam logic [RULE_W-1:0] BIRTH_HIGH_RESET   = RULE_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GRID_SIZE    = 3'd0,
		CFG_SURVIVE_LOW  = 3'd1,
		CFG_SURVIVE_HIGH = 3'd2,
		CFG_BIRTH_LOW    = 3'd3,
		CFG_BIRTH_HIGH   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [GRID_W-1:0] grid_size;
		logic [RULE_W-1:0] survive_low;
		logic [RULE_W-1:0] survive_high;
		logic [RULE_W-1:0] birth_low;
		logic [RULE_W-1:0] birth_high;
	} cfg_t;

	// Position and edge flags of one request, fixed at acceptance.
	typedef struct packed {
		logic [ADDR_W-1:0] ic;
		logic [ADDR_W-1:0] cr;
		logic [ADDR_W-1:0] cc;
		logic              b;
		logic              emit;
		logic              last;
		logic              top_edge;
		logic              bot_edge;
		logic              left_edge;
		logic              right_edge;
	} pos_t;

	typedef struct packed {
		logic top_edge;
		logic bot_edge;
		logic left_edge;
		logic right_edge;
	} edge_t;

endpackage

### rtl/core/lla_if.sv
// Valid/ready channels for the cell stream and the result stream.
interface lla_cell_if;
	logic valid;
	logic ready;
	logic cell_alive;

	modport source(output valid, output cell_alive, input ready);
	modport sink(input valid, input cell_alive, output ready);
endinterface

interface lla_result_if;
	import lla_pkg::*;

	logic              valid;
	logic              ready;
	logic              next_alive;
	logic [CELL_W-1:0] cell_row;
	logic [CELL_W-1:0] cell_col;
	logic              last_of_generation;

	modport source(output valid, output next_alive, output cell_row, output cell_col,
		output last_of_generation, input ready);
	modport sink(input valid, input next_alive, input cell_row, input cell_col,
		input last_of_generation, output ready);
endinterface

### rtl/core/life_like_automaton_stencil.sv
// Top level of the life-like automaton stencil: config, pipeline and result register.
// One generation of a square life-like automaton, one cell per clock unless stalled.
// Cells enter in raster order on the cells channel; after grid_size*grid_size cells,
// send grid_size+1 drain requests (values ignored) to flush the last results. Each
// cell (r,c) is reported one row plus one cell after it entered. The pipeline
// sustains one request per clock unless stalled: the line buffer memory does one read
// and one write per clock, and the neighbor count sits between the stage 1 register
// and the result register. Sizes outside 3..1024 are clamped. The line buffers need
// no clearing pass after reset. Write configuration only while the block is idle.
`include "life_like_automaton_stencil_defines.svh"

module life_like_automaton_stencil (
	input  logic                          clk,
	input  logic                          arst_n,
	lla_cell_if.sink                      cells,
	lla_result_if.source                  results,
	input  logic                          cfg_wr_en,
	input  logic [lla_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lla_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lla_pkg::*;

	cfg_t              cfg_q;
	pos_t              pos, pos_s1;
	edge_t             edges_s1;
	logic              valid_s1, advance, accept;
	logic [1:0]        rd_data;
	logic              alive;
	logic              res_valid_s2, res_alive_s2, res_last_s2;
	logic [CELL_W-1:0] res_row_s2, res_col_s2;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_size    <= GRID_RESET;
			cfg_q.survive_low  <= SURVIVE_LOW_RESET;
			cfg_q.survive_high <= SURVIVE_HIGH_RESET;
			cfg_q.birth_low    <= BIRTH_LOW_RESET;
			cfg_q.birth_high   <= BIRTH_HIGH_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_GRID_SIZE:    cfg_q.grid_size    <= cfg_data[GRID_W-1:0];
				CFG_SURVIVE_LOW:  cfg_q.survive_low  <= cfg_data[RULE_W-1:0];
				CFG_SURVIVE_HIGH: cfg_q.survive_high <= cfg_data[RULE_W-1:0];
				CFG_BIRTH_LOW:    cfg_q.birth_low    <= cfg_data[RULE_W-1:0];
				CFG_BIRTH_HIGH:   cfg_q.birth_high   <= cfg_data[RULE_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the result register is free or drains
	assign accept      = cells.valid && cells.ready;
	assign advance     = valid_s1 && (!res_valid_s2 || results.ready);
	assign cells.ready = !valid_s1 || advance;

	lla_position u_position (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.cell_alive (cells.cell_alive),
		.grid_size  (cfg_q.grid_size),
		.pos        (pos)
	);

	// Stage 1: hold the request position while the line buffers are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pos_s1 <= pos;
		end
	end

	lla_linebuf u_linebuf (
		.clk     (clk),
		.rd_en   (accept),
		.rd_addr (pos.ic),
		.wr_en   (advance),
		.wr_addr (pos_s1.ic),
		.wr_data ({rd_data[0], pos_s1.b}),
		.rd_data (rd_data)
	);

	assign edges_s1.top_edge   = pos_s1.top_edge;
	assign edges_s1.bot_edge   = pos_s1.bot_edge;
	assign edges_s1.left_edge  = pos_s1.left_edge;
	assign edges_s1.right_edge = pos_s1.right_edge;

	lla_rule u_rule (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.top    (rd_data[1]),
		.mid    (rd_data[0]),
		.b      (pos_s1.b),
		.edges  (edges_s1),
		.cfg    (cfg_q),
		.alive  (alive)
	);

	// Result register: load on an emitting request, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance && pos_s1.emit) begin
			res_valid_s2 <= 1'b1;
		end else if (results.ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && pos_s1.emit) begin
			res_alive_s2 <= alive;
			res_row_s2   <= CELL_W'(pos_s1.cr);
			res_col_s2   <= CELL_W'(pos_s1.cc);
			res_last_s2  <= pos_s1.last;
		end
	end

	assign results.valid              = res_valid_s2;
	assign results.next_alive         = res_alive_s2;
	assign results.cell_row           = res_row_s2;
	assign results.cell_col           = res_col_s2;
	assign results.last_of_generation = res_last_s2;

	`LLA_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(pos_s1), "stage 1 request changed while stalled")
	`LLA_ASSERT_IMPLY(a_last_corner, valid_s1 && pos_s1.last, pos_s1.emit && pos_s1.bot_edge && pos_s1.right_edge, "last cell is not the bottom right corner")
	`LLA_ASSERT_IMPLY(a_last_diag, results.valid && results.last_of_generation, results.cell_row == results.cell_col, "last result off the diagonal")

endmodule

### rtl/core/lla_position.sv
// Raster position counters: input row/column, reported cell and edge flags.
module lla_position (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      step,
	input  logic                      cell_alive,
	input  logic [lla_pkg::GRID_W-1:0] grid_size,
	output lla_pkg::pos_t             pos
);
	import lla_pkg::*;

	logic [ROW_W-1:0]  row_q, row_d, ir;
	logic [ROW_W-1:0]  s, s_m1, s_p1;
	logic [ROW_W-1:0]  ic_ext, ic_p1, cr_full, cc_full;
	logic [ADDR_W-1:0] col_q, col_d, ic;
	logic              restart, wrap, emit, last;

	// Saturate the grid side to the supported range
	always_comb begin
		if (int'(grid_size) < MIN_SIZE) begin
			s = ROW_W'(MIN_SIZE);
		end else if (int'(grid_size) > MAX_SIZE) begin
			s = ROW_W'(MAX_SIZE);
		end else begin
			s = ROW_W'(grid_size);
		end
	end

	assign s_m1 = s - ROW_W'(1);
	assign s_p1 = s + ROW_W'(1);

	// Restart at a new generation when the position lies outside the stream
	assign restart = (ROW_W'(col_q) >= s) || (row_q > s_p1) ||
		((row_q == s_p1) && (col_q != '0));
	assign ir     = restart ? '0 : row_q;
	assign ic     = restart ? '0 : col_q;
	assign ic_ext = ROW_W'(ic);

	// Reported cell trails the input by one row and one cell
	always_comb begin
		if (ic == '0) begin
			emit    = ir >= ROW_W'(2);
			cr_full = ir - ROW_W'(2);
			cc_full = s_m1;
		end else begin
			emit    = ir >= ROW_W'(1);
			cr_full = ir - ROW_W'(1);
			cc_full = ic_ext - ROW_W'(1);
		end
	end

	assign last  = emit && (cr_full == s_m1) && (cc_full == s_m1);
	assign ic_p1 = ic_ext + ROW_W'(1);
	assign wrap  = ic_p1 >= s;

	// Advance the input position
	always_comb begin
		if (last) begin
			col_d = '0;
			row_d = '0;
		end else if (wrap) begin
			col_d = '0;
			row_d = ir + ROW_W'(1);
		end else begin
			col_d = ADDR_W'(ic_p1);
			row_d = ir;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (step) begin
			row_q <= row_d;
			col_q <= col_d;
		end
	end

	assign pos.ic         = ic;
	assign pos.cr         = ADDR_W'(cr_full);
	assign pos.cc         = ADDR_W'(cc_full);
	assign pos.b          = (ir < s) ? cell_alive : 1'b0;
	assign pos.emit       = emit;
	assign pos.last       = last;
	assign pos.top_edge   = cr_full == '0;
	assign pos.bot_edge   = cr_full == s_m1;
	assign pos.left_edge  = cc_full == '0;
	assign pos.right_edge = cc_full == s_m1;

endmodule

### rtl/core/lla_linebuf.sv
// Two line buffers packed in one single-port-pair memory, upper row in bit 1.
module lla_linebuf (
	input  logic                      clk,
	input  logic                      rd_en,
	input  logic [lla_pkg::ADDR_W-1:0] rd_addr,
	input  logic                      wr_en,
	input  logic [lla_pkg::ADDR_W-1:0] wr_addr,
	input  logic [1:0]                wr_data,
	output logic [1:0]                rd_data
);
	import lla_pkg::*;

	logic [1:0] mem [MAX_SIZE];

	// Write the shifted column
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read; pass write data through on an address match
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

### rtl/core/lla_rule.sv
// 3x3 window register, neighbor count and survive/birth decision.
module lla_rule (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          top,
	input  logic          mid,
	input  logic          b,
	input  lla_pkg::edge_t edges,
	input  lla_pkg::cfg_t  cfg,
	output logic          alive
);
	import lla_pkg::*;

	localparam int         CENTRE     = 4;
	localparam logic [8:0] TOP_MASK   = 9'h049;
	localparam logic [8:0] BOT_MASK   = 9'h124;
	localparam logic [8:0] LEFT_MASK  = 9'h007;
	localparam logic [8:0] RIGHT_MASK = 9'h1C0;

	logic [8:0]        window_q, win_d, win_m;
	logic [RULE_W-1:0] cnt;

	// Shift in the new column on the right
	assign win_d = {b, mid, top, window_q[8:3]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (step) begin
			window_q <= win_d;
		end
	end

	// Drop neighbors that lie outside the grid
	always_comb begin
		win_m = win_d;
		if (edges.top_edge)   win_m = win_m & ~TOP_MASK;
		if (edges.bot_edge)   win_m = win_m & ~BOT_MASK;
		if (edges.left_edge)  win_m = win_m & ~LEFT_MASK;
		if (edges.right_edge) win_m = win_m & ~RIGHT_MASK;
	end

	// Count the eight neighbors
	always_comb begin
		cnt = '0;
		for (int i = 0; i < 9; i++) begin
			if (i != CENTRE) begin
				cnt = cnt + RULE_W'(win_m[i]);
			end
		end
	end

	always_comb begin
		if (win_m[CENTRE]) begin
			alive = (cfg.survive_low <= cnt) && (cnt <= cfg.survive_high);
		end else begin
			alive = (cfg.birth_low <= cnt) && (cnt <= cfg.birth_high);
		end
	end

endmodule
